FILE: rtl/assert_macros.svh
// Assertion macros for checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, muted during reset.
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: rtl/psg_pkg.sv
// Package for the three-voice sound generator: types, tables, helpers.
// No dependencies.
`timescale 1ns / 1ps
package psg_pkg;
   localparam int SampleBitsDefault = 16;
   localparam int NumRegs = 14;
   localparam int CfgWidth = 24;
   localparam logic [CfgWidth-1:0] CfgReset = 24'd2621440;

   localparam logic FuncWrite = 1'b0;
   localparam logic FuncTick  = 1'b1;

   localparam logic [3:0] RegMixer    = 4'd7;
   localparam logic [3:0] RegLevelA   = 4'd8;
   localparam logic [3:0] RegEnvLo    = 4'd11;
   localparam logic [3:0] RegEnvHi    = 4'd12;
   localparam logic [3:0] RegEnvShape = 4'd13;
   localparam logic [3:0] RegNoise    = 4'd6;

   typedef enum logic [1:0] {
      PH_NORM = 2'd0,
      PH_INV  = 2'd1,
      PH_HOLD = 2'd2
   } env_phase_type;

   // controller to datapath
   typedef struct packed {
      logic reg_write;   // apply write of the held item
      logic sample_load; // capture channel samples into output register
      logic load_count;  // compute master cycle count for the tick
      logic step_cycle;  // advance generators by one master cycle
   } psg_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic count_zero;  // no master cycles left
   } psg_status_type;

   function automatic logic [14:0] fixed_level(input logic [3:0] idx);
      logic [14:0] r;
      unique case (idx)
         4'd0: r = 15'd0;     4'd1: r = 15'd262;   4'd2: r = 15'd360;
         4'd3: r = 15'd524;   4'd4: r = 15'd721;   4'd5: r = 15'd1016;
         4'd6: r = 15'd1442;  4'd7: r = 15'd2064;  4'd8: r = 15'd2883;
         4'd9: r = 15'd4096;  4'd10: r = 15'd5800; 4'd11: r = 15'd8192;
         4'd12: r = 15'd11600; 4'd13: r = 15'd16384; 4'd14: r = 15'd23166;
         default: r = 15'd32767;
      endcase
      return r;
   endfunction

   function automatic logic [14:0] env_level(input logic [4:0] idx);
      logic [14:0] r;
      unique case (idx)
         5'd0: r = 15'd164;    5'd1: r = 15'd197;    5'd2: r = 15'd229;
         5'd3: r = 15'd262;    5'd4: r = 15'd295;    5'd5: r = 15'd360;
         5'd6: r = 15'd426;    5'd7: r = 15'd524;    5'd8: r = 15'd623;
         5'd9: r = 15'd721;    5'd10: r = 15'd852;   5'd11: r = 15'd1016;
         5'd12: r = 15'd1212;  5'd13: r = 15'd1442;  5'd14: r = 15'd1737;
         5'd15: r = 15'd2064;  5'd16: r = 15'd2425;  5'd17: r = 15'd2883;
         5'd18: r = 15'd3441;  5'd19: r = 15'd4096;  5'd20: r = 15'd4882;
         5'd21: r = 15'd5800;  5'd22: r = 15'd6881;  5'd23: r = 15'd8192;
         5'd24: r = 15'd9732;  5'd25: r = 15'd11600; 5'd26: r = 15'd13762;
         5'd27: r = 15'd16384; 5'd28: r = 15'd19496; 5'd29: r = 15'd23166;
         5'd30: r = 15'd27557; default: r = 15'd32767;
      endcase
      return r;
   endfunction
endpackage

FILE: rtl/psg_ctrl.sv
// Sequencer for the sound generator: handshake and master cycle loop.
// Depends on psg_pkg.
`timescale 1ns / 1ps
module psg_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_func,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output psg_pkg::psg_cmd_type    cmd,
   input  psg_pkg::psg_status_type status
);
   import psg_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LOAD = 3'b010,
      ST_RUN  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      take;

   // requests are taken only in idle with the output register free
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign take      = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (req_func == FuncTick) begin
                  cmd.sample_load = 1'b1;
                  rsp_valid_in    = 1'b1;
                  state_in        = ST_LOAD;
               end else begin
                  cmd.reg_write = 1'b1;
               end
            end
         end
         ST_LOAD: begin
            cmd.load_count = 1'b1;
            state_in       = ST_RUN;
         end
         ST_RUN: begin
            if (status.count_zero) begin
               state_in = ST_IDLE;
            end else begin
               cmd.step_cycle = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

FILE: rtl/psg_dp.sv
// Datapath for the sound generator: register file, generators, mixer.
// Depends on psg_pkg.
`timescale 1ns / 1ps
module psg_dp #(
   parameter int SAMPLE_BITS = psg_pkg::SampleBitsDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [3:0]                  req_reg_index,
   input  logic [7:0]                  req_reg_value,
   input  logic [psg_pkg::CfgWidth-1:0] ratio,
   input  psg_pkg::psg_cmd_type        cmd,
   output psg_pkg::psg_status_type     status,
   output logic signed [15:0]          rsp_sample_a,
   output logic signed [15:0]          rsp_sample_b,
   output logic signed [15:0]          rsp_sample_c,
   output logic signed [15:0]          rsp_sample_mono
);
   import psg_pkg::*;

   localparam int DropBits = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;
   localparam logic [14:0] MagMask = 15'h7fff << DropBits;

   logic [7:0]  regs_ff [NumRegs];
   logic [2:0]  tpre_ff [3];
   logic [11:0] tcnt_ff [3];
   logic [2:0]  tlev_ff;
   logic [3:0]  npre_ff;
   logic [4:0]  ncnt_ff;
   logic [16:0] nsh_ff;
   logic [3:0]  epre_ff;
   logic [15:0] ecnt_ff;
   logic [4:0]  estep_ff;
   env_phase_type ephase_ff;
   logic [15:0] frac_ff;
   logic [8:0]  whole_ff;
   logic signed [15:0] sa_ff, sb_ff, sc_ff, sm_ff;

   logic [15:0] env_per;
   assign env_per = {regs_ff[RegEnvHi], regs_ff[RegEnvLo]};

   // channel amplitudes
   logic signed [15:0] chv [3];
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         logic toff, noff, pos;
         logic [7:0] lev;
         logic [14:0] mag;
         toff = regs_ff[RegMixer][ch];
         noff = regs_ff[RegMixer][3+ch];
         lev  = regs_ff[RegLevelA + 4'(ch)];
         pos  = (tlev_ff[ch] | toff) & (nsh_ff[0] | noff);
         mag  = lev[4] ? env_level(estep_ff) : fixed_level(lev[3:0]);
         mag  = mag & MagMask;
         if (toff && noff) chv[ch] = '0;
         else chv[ch] = pos ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
      end
   end

   // mean by three: multiply |sum| by reciprocal, exact for |sum| < 2^17
   logic signed [17:0] sum3;
   logic [16:0] sum_abs;
   logic [34:0] prod;
   logic [16:0] quo;
   assign sum3    = 18'(chv[0]) + 18'(chv[1]) + 18'(chv[2]);
   assign sum_abs = sum3[17] ? 17'(-sum3) : 17'(sum3);
   assign prod    = 35'(sum_abs) * 35'd43691;
   assign quo     = 17'(prod >> 17);

   assign rsp_sample_a    = sa_ff;
   assign rsp_sample_b    = sb_ff;
   assign rsp_sample_c    = sc_ff;
   assign rsp_sample_mono = sm_ff;
   assign status.count_zero = (whole_ff == 9'd0);

   // ratio plus kept fraction; whole part reaches 256 at the top ratio
   logic [24:0] total;
   assign total = 25'(ratio) + 25'(frac_ff);

   // envelope shape
   logic [7:0] shape;
   logic att, cont, hold, alt;
   assign shape = regs_ff[RegEnvShape];
   assign att   = shape[2];
   assign cont  = shape[3];
   assign hold  = cont ? shape[0] : 1'b1;
   assign alt   = cont ? shape[1] : att;

   logic [4:0]    estep_nx;
   env_phase_type ephase_nx;
   always_comb begin
      logic [5:0] v;
      estep_nx  = estep_ff;
      ephase_nx = ephase_ff;
      v = '0;
      unique case (ephase_ff)
         PH_NORM: begin
            v = att ? 6'({1'b0, estep_ff}) + 6'd1 : 6'({1'b0, estep_ff}) - 6'd1;
            if (v[5]) begin
               estep_nx = ((!att ^ alt ^ hold) && cont) ? 5'd31 : 5'd0;
               if (hold) ephase_nx = PH_HOLD;
               else if (alt) ephase_nx = PH_INV;
            end else estep_nx = v[4:0];
         end
         PH_INV: begin
            v = att ? 6'({1'b0, estep_ff}) - 6'd1 : 6'({1'b0, estep_ff}) + 6'd1;
            if (v[5]) begin
               estep_nx  = att ? 5'd0 : 5'd31;
               ephase_nx = PH_NORM;
            end else estep_nx = v[4:0];
         end
         default: estep_nx = ((att ^ alt) && cont) ? 5'd31 : 5'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumRegs; i++) regs_ff[i] <= '0;
         for (int i = 0; i < 3; i++) begin
            tpre_ff[i] <= '0;
            tcnt_ff[i] <= '0;
         end
         tlev_ff   <= '0;
         npre_ff   <= '0;
         ncnt_ff   <= '0;
         nsh_ff    <= '0;
         epre_ff   <= '0;
         ecnt_ff   <= '0;
         estep_ff  <= 5'd31;
         ephase_ff <= PH_NORM;
         frac_ff   <= '0;
         whole_ff  <= '0;
      end else begin
         if (cmd.reg_write && req_reg_index < 4'(NumRegs)) begin
            regs_ff[req_reg_index] <= req_reg_value;
            if (req_reg_index == RegEnvShape) begin
               ephase_ff <= PH_NORM;
               ecnt_ff   <= env_per;
               estep_ff  <= req_reg_value[2] ? 5'd0 : 5'd31;
            end
         end
         if (cmd.load_count) begin
            whole_ff <= total[24:16];
            frac_ff  <= total[15:0];
         end
         if (cmd.step_cycle) begin
            whole_ff <= whole_ff - 9'd1;
            for (int ch = 0; ch < 3; ch++) begin
               tpre_ff[ch] <= tpre_ff[ch] + 3'd1;
               if (tpre_ff[ch] == 3'd7) begin
                  if (tcnt_ff[ch] != 12'd0) tcnt_ff[ch] <= tcnt_ff[ch] - 12'd1;
                  else begin
                     tcnt_ff[ch] <= {regs_ff[2*ch+1][3:0], regs_ff[2*ch]};
                     tlev_ff[ch] <= ~tlev_ff[ch];
                  end
               end
            end
            npre_ff <= npre_ff + 4'd1;
            if (npre_ff == 4'd15) begin
               if (ncnt_ff != 5'd0) ncnt_ff <= ncnt_ff - 5'd1;
               else begin
                  ncnt_ff <= regs_ff[RegNoise][4:0];
                  nsh_ff  <= {nsh_ff[0] ^ nsh_ff[3] ^ (nsh_ff == 17'd0), nsh_ff[16:1]};
               end
            end
            epre_ff <= epre_ff + 4'd1;
            if (epre_ff == 4'd15) begin
               if (ecnt_ff != 16'd0) ecnt_ff <= ecnt_ff - 16'd1;
               else begin
                  ecnt_ff   <= env_per;
                  estep_ff  <= estep_nx;
                  ephase_ff <= ephase_nx;
               end
            end
         end
      end
   end

   // output register, payload only
   always_ff @(posedge clock) begin
      if (cmd.sample_load) begin
         sa_ff <= chv[0];
         sb_ff <= chv[1];
         sc_ff <= chv[2];
         sm_ff <= sum3[17] ? -$signed({1'b0, quo[14:0]}) : $signed({1'b0, quo[14:0]});
      end
   end
endmodule

FILE: rtl/psg_three_voice_sound_generator.sv
// Top level of the three-voice sound generator; joins sequencer, datapath, CSR.
// Depends on psg_pkg, psg_ctrl, psg_dp.
// Register writes and ticks are taken only in idle. Sample tick: result valid the cycle after the transfer;
// the block then walks the tick's whole master cycles w one per clock, w being the whole part of the
// Q8.16 ratio plus kept fraction, and takes the next item once idle with the output register free.
// Reset (synchronous, high) clears register file, generators and fraction.
`timescale 1ns / 1ps
module psg_three_voice_sound_generator #(
   parameter int SAMPLE_BITS = psg_pkg::SampleBitsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_func,
   input  logic [3:0]         req_reg_index,
   input  logic [7:0]         req_reg_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_sample_a,
   output logic signed [15:0] rsp_sample_b,
   output logic signed [15:0] rsp_sample_c,
   output logic signed [15:0] rsp_sample_mono,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [1:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import psg_pkg::*;

   psg_cmd_type    cmd;
   psg_status_type status;
   logic [CfgWidth-1:0] ratio_ff;

   // single CSR at byte address 0: Q8.16 master cycles per sample
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'd0) ? 32'(ratio_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= CfgReset;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0) begin
         ratio_ff <= csr_pwdata[CfgWidth-1:0];
      end
   end

   psg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_func),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   psg_dp #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_reg_index   (req_reg_index),
      .req_reg_value   (req_reg_value),
      .ratio           (ratio_ff),
      .cmd             (cmd),
      .status          (status),
      .rsp_sample_a    (rsp_sample_a),
      .rsp_sample_b    (rsp_sample_b),
      .rsp_sample_c    (rsp_sample_c),
      .rsp_sample_mono (rsp_sample_mono)
   );
endmodule

FILE: rtl/psg_checker.sv
// Port-level checker for the sound generator, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module psg_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_func,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_sample_a,
   input logic               csr_pready
);
   `CHK_NEXT(a_tick_rsp, clock, reset, req_valid && !req_stall && req_func, rsp_valid, "tick without result")
   `CHK_NEXT(a_write_busy, clock, reset, req_valid && !req_stall && !req_func && !rsp_valid, !rsp_valid, "write made a result")
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_sample_a), "stalled result changed")
   `CHK_IMPL(a_pready, clock, reset, 1'b1, csr_pready, "pready low")
endmodule

bind psg_three_voice_sound_generator psg_checker u_chk (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_func     (req_func),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_sample_a (rsp_sample_a),
   .csr_pready   (csr_pready)
);
